### src/tmps_pkg.sv
package tmps_pkg;

    localparam int unsigned OP_W = 2;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned ELEM_W = 16;
    localparam int unsigned SIZE_W = 7;
    localparam int unsigned RES_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_READ_C  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INNER = 5'b00010,
        ST_OUTER = 5'b00100,
        ST_TRI   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

### src/triangular_matrix_product_sum_unit.sv
// Channel  | Ports                                     | Dir | Handshake
// input    | operation, row, col, element_value        | in  | start && !busy
// result   | product_value                             | out | done, one cycle
// config   | matrix_size_we, matrix_size_wdata         | in  | matrix_size_we
// Writes of A or B go straight into the stores. A read of C at size n walks
// the B store once per outer term, then sums the triangular A terms up to
// min(row,col). Reset clears control and sets the size to the maximum; the
// stores keep no reset. The receiver cannot stall: done pulses for one
// cycle.
module triangular_matrix_product_sum_unit #(
    parameter int unsigned MAX_SIZE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tmps_pkg::OP_W-1:0]       operation,
    input  logic [tmps_pkg::IDX_W-1:0]      row,
    input  logic [tmps_pkg::IDX_W-1:0]      col,
    input  logic signed [tmps_pkg::ELEM_W-1:0] element_value,
    input  logic                            matrix_size_we,
    input  logic [tmps_pkg::SIZE_W-1:0]     matrix_size_wdata,
    output logic                            done,
    output logic signed [tmps_pkg::RES_W-1:0] product_value
);
    import tmps_pkg::*;

    localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int unsigned MW = 2 * AW;
    localparam int unsigned DEPTH = 1 << MW;

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] n_eff;
    state_t state_reg;
    logic [AW-1:0] r_reg, c_reg, k_reg, m_reg, lim_reg;
    logic [SIZE_W-1:0] n_reg;
    logic rd_v_reg;
    logic signed [ELEM_W-1:0] a_q, b1_q, b2_q, a2_q;
    logic signed [47:0] d_reg;
    logic signed [RES_W-1:0] acc_reg;
    logic signed [RES_W-1:0] res_reg;
    logic done_reg;

    logic [MW-1:0] a_ra, a2_ra, b1_ra, b2_ra;
    logic in_range;
    logic signed [31:0] bprod, aprod;
    logic signed [63:0] fprod;

    assign n_eff = (size_reg > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_reg;
    assign in_range = ({1'b0, row} < n_eff) && ({1'b0, col} < n_eff);
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign product_value = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_W'(MAX_SIZE);
        else if (matrix_size_we)
            size_reg <= matrix_size_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy && in_range && op_t'(operation) == OP_WRITE_A)
            a_mem[{row[AW-1:0], col[AW-1:0]}] <= element_value;
        if (start && !busy && in_range && op_t'(operation) == OP_WRITE_B)
            b_mem[{row[AW-1:0], col[AW-1:0]}] <= element_value;
    end

    // ST_INNER: B[k][m], B[c][m] over m; ST_OUTER: A[r][k]; ST_TRI: A[k][r], A[k][c]
    always_comb
    begin
        b1_ra = {k_reg, m_reg};
        b2_ra = {c_reg, m_reg};
        if (state_reg == ST_TRI)
        begin
            a_ra  = {k_reg, r_reg};
            a2_ra = {k_reg, c_reg};
        end
        else
        begin
            a_ra  = {r_reg, k_reg};
            a2_ra = {r_reg, k_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        a_q  <= a_mem[a_ra];
        a2_q <= a_mem[a2_ra];
        b1_q <= b_mem[b1_ra];
        b2_q <= b_mem[b2_ra];
    end

    assign bprod = b1_q * b2_q;
    assign aprod = a_q * a2_q;
    assign fprod = a_q * d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            rd_v_reg    <= 1'b0;
            r_reg       <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            m_reg       <= '0;
            lim_reg     <= '0;
            n_reg       <= '0;
            d_reg       <= '0;
            acc_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    rd_v_reg <= 1'b0;
                    if (start && op_t'(operation) == OP_READ_C)
                    begin
                        if (!in_range)
                        begin
                            res_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            r_reg   <= row[AW-1:0];
                            c_reg   <= col[AW-1:0];
                            k_reg   <= row[AW-1:0];
                            m_reg   <= '0;
                            n_reg   <= n_eff;
                            lim_reg <= (row < col) ? row[AW-1:0] : col[AW-1:0];
                            acc_reg <= '0;
                            d_reg   <= '0;
                            state_reg <= ST_INNER;
                        end
                    end
                end
                ST_INNER:
                begin
                    rd_v_reg    <= 1'b1;
                    if (rd_v_reg)
                        d_reg <= d_reg + 48'(bprod);
                    if ({1'b0, m_reg} == n_reg - 1'b1)
                        state_reg <= ST_OUTER;
                    else
                        m_reg <= m_reg + 1'b1;
                end
                ST_OUTER:
                begin
                    // drain last product, then A[r][k] data is valid next
                    if (rd_v_reg)
                    begin
                        d_reg    <= d_reg + 48'(bprod);
                        rd_v_reg <= 1'b0;
                    end
                    else
                    begin
                        acc_reg <= acc_reg + fprod;
                        d_reg   <= '0;
                        m_reg   <= '0;
                        if ({1'b0, k_reg} == n_reg - 1'b1)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_TRI;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_INNER;
                        end
                    end
                end
                ST_TRI:
                begin
                    rd_v_reg <= 1'b1;
                    if (rd_v_reg)
                        acc_reg <= acc_reg + (64'(aprod) <<< 8);
                    if (k_reg == lim_reg)
                        state_reg <= ST_DONE;
                    else
                        k_reg <= k_reg + 1'b1;
                end
                ST_DONE:
                begin
                    res_reg   <= acc_reg + (64'(aprod) <<< 8);
                    done_reg  <= 1'b1;
                    rd_v_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result given while busy");
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (done && state_reg == ST_IDLE))
        else $error("read finished without result");
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation != OP_READ_C) |=> !busy)
        else $error("write left block busy");

endmodule
